@@ rtl/bus_pkg.sv @@
// ---------------------------------------------------------------------------
// bus_pkg: shared types for the bounded unique set
// Command and status codes, controller states and the bundles that pass
// between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package bus_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    lookup;
    logic    append;
    logic    remove;
    logic    load_out;
    status_t status;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       present;
    logic       full;
  } dstat_t;

endpackage

`default_nettype wire

@@ rtl/bus_ctrl.sv @@
// ---------------------------------------------------------------------------
// bus_ctrl: sequencer for the bounded unique set
// Steps each word through capture, lookup and execute, decides the outcome
// and owns the result valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module bus_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire bus_pkg::dstat_t dstat,
  output bus_pkg::ctrl_t       ctrl
);

  bus_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bus_pkg::S_IDLE: if (in_valid) state_nxt = bus_pkg::S_LOOK;
      bus_pkg::S_LOOK: state_nxt = bus_pkg::S_EXEC;
      bus_pkg::S_EXEC: if (out_free) state_nxt = bus_pkg::S_IDLE;
      default:         state_nxt = bus_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    unique case (state_r)
      bus_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        ctrl.capture = in_valid;
      end
      bus_pkg::S_LOOK: begin
        ctrl.lookup = 1'b1;
      end
      bus_pkg::S_EXEC: begin
        ctrl.load_out = out_free;
        unique case (bus_pkg::cmd_t'(dstat.cmd))
          bus_pkg::CMD_ADD: begin
            if (dstat.full) begin
              ctrl.status = bus_pkg::ST_FULL;
            end else if (dstat.present) begin
              ctrl.status = bus_pkg::ST_DUP;
            end else begin
              ctrl.status = bus_pkg::ST_OK;
              ctrl.append = out_free;
            end
          end
          bus_pkg::CMD_REMOVE: begin
            if (dstat.present) begin
              ctrl.status = bus_pkg::ST_OK;
              ctrl.remove = out_free;
            end else begin
              ctrl.status = bus_pkg::ST_MISSING;
            end
          end
          default: ctrl.status = bus_pkg::ST_OK;  // query and unused code
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (ctrl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bus_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.append && ctrl.remove))
    else $error("append and remove in the same cycle");

  a_update_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.append || ctrl.remove) |-> ctrl.load_out)
    else $error("store update without result load");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("pending result dropped");

endmodule

`default_nettype wire

@@ rtl/bus_dpath.sv @@
// ---------------------------------------------------------------------------
// bus_dpath: key cells, compare row and result register
// Cells are packed from index 0; every cell compares against the captured
// key at once and a remove shifts the tail down one place.
// ---------------------------------------------------------------------------
`default_nettype none

module bus_dpath #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [1:0]     in_cmd,
  input  wire logic [31:0]    in_key,
  input  wire bus_pkg::ctrl_t ctrl,
  output bus_pkg::dstat_t     dstat,
  output logic [1:0]          out_status,
  output logic                out_found,
  output logic [4:0]          out_fill
);

  localparam int USED_W = $clog2(CAPACITY + 1);
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [KEY_WIDTH-1:0] cells_r [CAPACITY];
  logic [KEY_WIDTH-1:0] key_r;
  logic [1:0]           cmd_r;
  logic [USED_W-1:0]    used_r, used_nxt;
  logic [CAPACITY-1:0]  match_r, match_nxt, tail_mask;
  logic [1:0]           status_r;
  logic                 found_r;
  logic [4:0]           fill_r;

  logic [KEY_WIDTH+31:0] key_wide;
  logic [USED_W+4:0]     fill_wide;
  logic                  present;

  assign key_wide  = {KEY_WIDTH'(0), in_key};
  assign present   = |match_r;
  assign fill_wide = {5'd0, used_nxt};

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_nxt[i] = (USED_W'(i) < used_r) && (cells_r[i] == key_r);
    end
  end

  // cells at and after the first hit
  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      acc          = acc | match_r[i];
      tail_mask[i] = acc;
    end
  end

  always_comb begin
    used_nxt = used_r;
    priority if (ctrl.append) begin
      used_nxt = used_r + USED_W'(1);
    end else if (ctrl.remove) begin
      used_nxt = used_r - USED_W'(1);
    end
  end

  assign dstat.cmd     = cmd_r;
  assign dstat.present = present;
  assign dstat.full    = (used_r == USED_W'(CAPACITY));

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      key_r <= key_wide[KEY_WIDTH-1:0];
      cmd_r <= in_cmd;
    end
    if (ctrl.lookup) begin
      match_r <= match_nxt;
    end
    if (ctrl.load_out) begin
      status_r <= ctrl.status;
      found_r  <= present;
      fill_r   <= fill_wide[4:0];
    end
    if (ctrl.append) begin
      cells_r[used_r[IDX_W-1:0]] <= key_r;
    end
    if (ctrl.remove) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (tail_mask[i]) cells_r[i] <= cells_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  assign out_status = status_r;
  assign out_found  = found_r;
  assign out_fill   = fill_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(CAPACITY))
    else $error("fill count above capacity");

  a_keys_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_nxt))
    else $error("key stored twice");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.append |-> (used_r != USED_W'(CAPACITY)) && !present)
    else $error("append into full store or duplicate");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.remove |-> present ##1 (used_r == $past(used_r) - USED_W'(1)))
    else $error("remove without hit or count not decremented");

endmodule

`default_nettype wire

@@ rtl/bounded_unique_set_unit.sv @@
// From input accept, each word goes through lookup and then execute before its result is valid.
// Each word passes through capture, lookup and execute before the next is taken; a word is taken only
// in the idle state, so a waiting result holds execute and stalls the input as well.
// Reset: synchronous, active low; clears controller state and the fill count.
// Key cells are not cleared; only cells below the fill count are ever compared.
// ---------------------------------------------------------------------------
// bounded_unique_set_unit: fixed capacity set of unique keys
// Add, remove with compaction, and membership query; one result per command.
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_unique_set_unit #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [31:0] in_key,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic             out_found,
  output logic [4:0]       out_fill
);

  bus_pkg::ctrl_t  ctrl;
  bus_pkg::dstat_t dstat;

  bus_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dstat     (dstat),
    .ctrl      (ctrl)
  );

  bus_dpath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_cmd     (in_cmd),
    .in_key     (in_key),
    .ctrl       (ctrl),
    .dstat      (dstat),
    .out_status (out_status),
    .out_found  (out_found),
    .out_fill   (out_fill)
  );

endmodule

`default_nettype wire

@@ tb/set_checker.sv @@
// ---------------------------------------------------------------------------
// set_checker: scoreboard for the bounded unique set
// Watches the command and result channels. Keeps its own copy of the stored
// keys, predicts status, found and fill for every accepted command word, and
// compares each accepted result word with the oldest prediction.
// ---------------------------------------------------------------------------
module set_checker #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_key,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic        out_found,
  input  logic [4:0]  out_fill,
  output int          errors,
  output int          pending
);

  typedef struct {
    bus_pkg::status_t status;
    logic             found;
    logic [4:0]       fill;
  } set_result_t;

  set_result_t expected_q [$];
  logic [31:0] stored_keys [$];

  // Applies one command to the shadow store and returns the result word.
  // Codes other than add and remove leave the store untouched.
  function automatic set_result_t apply_command(logic [1:0] cmd, logic [31:0] key);
    set_result_t r;
    int          pos;
    pos = -1;
    foreach (stored_keys[i])
      if (pos < 0 && stored_keys[i] == key) pos = i;
    r.found  = (pos >= 0);
    r.status = bus_pkg::ST_OK;
    if (cmd == bus_pkg::CMD_ADD) begin
      if (stored_keys.size() >= CAPACITY) r.status = bus_pkg::ST_FULL;
      else if (r.found) r.status = bus_pkg::ST_DUP;
      else stored_keys.push_back(key);
    end else if (cmd == bus_pkg::CMD_REMOVE) begin
      if (!r.found) r.status = bus_pkg::ST_MISSING;
      else stored_keys.delete(pos);
    end
    r.fill = 5'(stored_keys.size());
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    set_result_t want;
    if (!rst_n) begin
      expected_q.delete();
      stored_keys.delete();
      errors  = 0;
      pending = 0;
    end else begin
      // result side first: a word leaving now belongs to an earlier command
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result word, fill", out_fill, -1);
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status) report("status", out_status, want.status);
          if (out_found !== want.found) report("found", out_found, want.found);
          if (out_fill !== want.fill) report("fill", out_fill, want.fill);
        end
      end
      if (in_valid && in_ready)
        expected_q.push_back(apply_command(in_cmd, in_key));
      pending = expected_q.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench: top level for the bounded unique set unit
// Drives directed and random command words with random idle gaps on both
// channels, including one long result-side stall, and gives the verdict
// from the failure count of the scoreboard.
// ---------------------------------------------------------------------------
module testbench;

  localparam int CAPACITY = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int POOL_SIZE = 20;
  localparam int PHASES = 24;
  localparam int PHASE_WORDS = 60;

  typedef enum int {
    BIAS_FILL,
    BIAS_DRAIN,
    BIAS_MIXED
  } bias_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_cmd = bus_pkg::CMD_ADD;
  logic [31:0] in_key = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic        out_found;
  logic [4:0]  out_fill;

  int errors;
  int pending;
  int words_in = 0;
  bit quiet = 1'b0;
  logic [31:0] key_pool [POOL_SIZE];

  bounded_unique_set_unit #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (32)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_key     (in_key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_found  (out_found),
    .out_fill   (out_fill)
  );

  set_checker #(
    .CAPACITY (CAPACITY)
  ) checker_inst (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_key     (in_key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_found  (out_found),
    .out_fill   (out_fill),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(logic [1:0] cmd, logic [31:0] key);
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    do @(posedge clk); while (!in_ready);
    words_in++;
  endtask

  task automatic idle_in(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_gapped(logic [1:0] cmd, logic [31:0] key);
    send_word(cmd, key);
    idle_in(quiet ? 0 : gap_len());
  endtask

  function automatic logic [31:0] pick_key();
    int          r;
    logic [31:0] k;
    r = $urandom_range(0, 99);
    k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 80) return k;
    // near miss: one bit away from a pool key
    if (r < 90) return k ^ (32'd1 << $urandom_range(0, 31));
    return $urandom;
  endfunction

  // result side: random stalls, plus one long hold-off to back up the input
  initial begin
    int n;
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && words_in >= 300) begin
        held = 1'b1;
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (399) @(negedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          @(negedge clk);
          out_ready <= 1'b0;
          repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        out_ready <= 1'b1;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  initial begin
    bias_t      bias;
    int         add_pct;
    int         rm_pct;
    int         r;
    logic [1:0] cmd;
    logic [31:0] base;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty store, extreme keys, duplicate, full store, compaction
    send_gapped(bus_pkg::CMD_QUERY, 32'h0000_0000);
    send_gapped(bus_pkg::CMD_REMOVE, 32'h0000_0000);
    send_gapped(bus_pkg::CMD_ADD, 32'h0000_0000);
    send_gapped(bus_pkg::CMD_ADD, 32'hFFFF_FFFF);
    send_gapped(bus_pkg::CMD_ADD, 32'h0000_0000);
    for (int i = 0; i < CAPACITY - 2; i++)
      send_gapped(bus_pkg::CMD_ADD, 32'h5A00_0000 | (32'd1 << i));
    // full check wins over the duplicate check
    send_gapped(bus_pkg::CMD_ADD, 32'hFFFF_FFFF);
    send_gapped(bus_pkg::CMD_ADD, 32'h1234_5678);
    send_gapped(CMD_UNUSED, 32'hFFFF_FFFF);
    send_gapped(bus_pkg::CMD_REMOVE, 32'h0000_0000);
    send_gapped(bus_pkg::CMD_REMOVE, 32'h5A00_0040);
    send_gapped(bus_pkg::CMD_REMOVE, 32'h5A00_2000);
    send_gapped(bus_pkg::CMD_QUERY, 32'h5A00_0040);

    for (int p = 0; p < PHASES; p++) begin
      bias  = bias_t'($urandom_range(0, 2));
      quiet = ($urandom_range(0, 3) == 0);
      base  = $urandom;
      for (int i = 0; i < POOL_SIZE; i++)
        key_pool[i] = (i % 2 == 0) ? 32'($urandom) : base ^ (32'd1 << $urandom_range(0, 31));
      case (bias)
        BIAS_FILL: begin
          add_pct = 60;
          rm_pct  = 20;
        end
        BIAS_DRAIN: begin
          add_pct = 20;
          rm_pct  = 60;
        end
        default: begin
          add_pct = 40;
          rm_pct  = 40;
        end
      endcase
      for (int i = 0; i < PHASE_WORDS; i++) begin
        r = $urandom_range(0, 99);
        if (r < add_pct) cmd = bus_pkg::CMD_ADD;
        else if (r < add_pct + rm_pct) cmd = bus_pkg::CMD_REMOVE;
        else if (r < 97) cmd = bus_pkg::CMD_QUERY;
        else cmd = CMD_UNUSED;
        send_gapped(cmd, pick_key());
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
